[hdl/c2s_pkg.sv]
package c2s_pkg;

	// CORDIC datapath width: coordinates are pre-scaled to about 2^39 and grow by the gain
	localparam int DW = 46;
	// angle accumulator, units of 2pi/2^32, with headroom for the half-turn offset
	localparam int AW = 34;
	localparam int TABLE_LEN = 24;
	localparam logic [20:0] GAIN_Q20 = 21'd1726752;

	// atan(2^-i) in units of 2pi/2^32
	localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic y_zero;
		logic x_zero;
		logic x_neg;
		logic y_pos;
		logic z_zero;
		logic z_neg;
	} c2s_flags_t;

endpackage

[hdl/cartesian_to_spherical.sv]
// Cartesian to spherical conversion of a stream of points.
// Input channel: in_valid / in_stall with pos_x, pos_y, pos_z (signed, 8 fraction bits).
// Output channel: out_valid / out_stall with radius (8 fraction bits), azimuth in
// [0, 2pi) and polar angle from +z in [0, pi], both in units of 2pi/2^ANGLE_BITS.
// Throughput: one point per cycle unless out_stall holds the output. Every stage is one
// register level, and a new point may enter each cycle while earlier points are still in flight.
// The pipeline depth is set by the two CORDIC vectoring chains (azimuth, then polar, one
// micro-rotation per stage) that run alongside a one-bit-per-stage square root; the
// output register follows them.
// When the output item is held by out_stall the whole pipeline holds and in_stall
// rises; bubbles never stall, so an empty output register keeps the pipe moving.
// Reset clears all valid bits; no item is in flight after reset and in_stall is low.
// The block has no state besides the pipeline: items are independent.
module cartesian_to_spherical
	import c2s_pkg::*;
#(
	parameter int COORD_BITS = 18,
	parameter int ANGLE_BITS = 16,
	parameter int ROTATION_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	output logic out_valid,
	input  logic out_stall,
	output logic [COORD_BITS-1:0] radius,
	output logic [ANGLE_BITS-1:0] azimuth,
	output logic [ANGLE_BITS-1:0] polar
);

	localparam int CB = COORD_BITS;
	localparam int AB = ANGLE_BITS;
	localparam int R = ROTATION_STEPS;
	localparam int PRESCALE = 40 - CB;
	localparam int RW = CB + 3;
	localparam int SW = 2 * CB;
	localparam int M = (2 * R + 2 > CB + 1) ? 2 * R + 2 : CB + 1;

	localparam logic signed [AW-1:0] RND = AW'(64'd1 << (31 - AB));
	localparam logic signed [AW-1:0] HALF32 = AW'(64'd1 << 31);
	localparam logic signed [AW-1:0] QUARTER32 = AW'(64'd1 << 30);
	localparam logic [AB-1:0] ANG_QUARTER = AB'(1) << (AB - 2);
	localparam logic [AB-1:0] ANG_HALF = AB'(1) << (AB - 1);
	localparam logic [AB-1:0] ANG_3QUARTER = AB'(3) << (AB - 2);

	logic en;

	logic vld_s [1:M];
	logic signed [DW-1:0] p_s [1:M];
	logic signed [DW-1:0] q_s [1:M];
	logic signed [AW-1:0] acc_s [1:M];
	logic [DW-1:0] zg_s [1:M];
	logic [AB-1:0] azo_s [1:M];
	c2s_flags_t fl_s [1:M];
	logic [RW-1:0] rem_s [1:M];
	logic [CB-1:0] root_s [1:M];
	logic [SW-1:0] n_s [1:M];

	logic vld_q;
	logic [CB-1:0] radius_q;
	logic [AB-1:0] azimuth_q;
	logic [AB-1:0] polar_q;

	// advance everything unless the result register is full and held
	assign en = !(vld_q && out_stall);
	assign in_stall = !en;

	// ---------------- stage 1: scale, fold to the right half plane, square ----------------
	logic [CB-1:0] ax, ay, az;
	logic [SW-1:0] sq_sum;
	logic [CB+20:0] zprod;
	logic [DW-1:0] zg_n;
	logic signed [DW-1:0] cx, cy;
	c2s_flags_t fl_n;

	always_comb begin
		ax = unsigned'(pos_x[CB-1] ? -pos_x : pos_x);
		ay = unsigned'(pos_y[CB-1] ? -pos_y : pos_y);
		az = unsigned'(pos_z[CB-1] ? -pos_z : pos_z);
		sq_sum = SW'(ax) * SW'(ax) + SW'(ay) * SW'(ay) + SW'(az) * SW'(az);
		zprod = (CB + 21)'(az) * (CB + 21)'(GAIN_Q20);
		cx = DW'(pos_x) <<< PRESCALE;
		cy = DW'(pos_y) <<< PRESCALE;
		fl_n.y_zero = (pos_y == '0);
		fl_n.x_zero = (pos_x == '0);
		fl_n.x_neg = pos_x[CB-1];
		fl_n.y_pos = !pos_y[CB-1] && (pos_y != '0);
		fl_n.z_zero = (pos_z == '0);
		fl_n.z_neg = pos_z[CB-1];
	end

	if (PRESCALE >= 20) begin : g_zg_up
		assign zg_n = DW'(zprod) << (PRESCALE - 20);
	end else begin : g_zg_dn
		assign zg_n = DW'(zprod >> (20 - PRESCALE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fl_n.x_neg) begin
				p_s[1] <= -cx;
				q_s[1] <= -cy;
				acc_s[1] <= HALF32;
			end else begin
				p_s[1] <= cx;
				q_s[1] <= cy;
				acc_s[1] <= '0;
			end
			zg_s[1] <= zg_n;
			azo_s[1] <= '0;
			fl_s[1] <= fl_n;
			rem_s[1] <= '0;
			root_s[1] <= '0;
			n_s[1] <= sq_sum;
		end
	end

	// ---------------- stages 2..M ----------------
	for (genvar k = 2; k <= M; k++) begin : g_st
		logic signed [DW-1:0] p_n, q_n;
		logic signed [AW-1:0] acc_n;
		logic [AB-1:0] azo_n;
		logic [RW-1:0] rem_n;
		logic [CB-1:0] root_n;

		if (k <= R + 1) begin : g_az
			localparam int I = k - 2;
			localparam logic signed [AW-1:0] ATV = AW'(ATAN_TURN32[I]);
			always_comb begin
				azo_n = azo_s[k-1];
				if (q_s[k-1] < 0) begin
					p_n = p_s[k-1] - (q_s[k-1] >>> I);
					q_n = q_s[k-1] + (p_s[k-1] >>> I);
					acc_n = acc_s[k-1] - ATV;
				end else begin
					p_n = p_s[k-1] + (q_s[k-1] >>> I);
					q_n = q_s[k-1] - (p_s[k-1] >>> I);
					acc_n = acc_s[k-1] + ATV;
				end
			end
		end else if (k == R + 2) begin : g_prep
			logic signed [AW-1:0] rsum;
			always_comb begin
				rsum = acc_s[k-1] + RND;
				p_n = signed'(zg_s[k-1]);
				q_n = (p_s[k-1] < 0) ? '0 : p_s[k-1];
				acc_n = '0;
				priority if (fl_s[k-1].y_zero) begin
					azo_n = fl_s[k-1].x_neg ? ANG_HALF : '0;
				end else if (fl_s[k-1].x_zero) begin
					azo_n = fl_s[k-1].y_pos ? ANG_QUARTER : ANG_3QUARTER;
				end else begin
					azo_n = rsum[31 -: AB];
				end
			end
		end else if (k <= 2 * R + 2) begin : g_pol
			localparam int I = k - R - 3;
			localparam logic signed [AW-1:0] ATV = AW'(ATAN_TURN32[I]);
			always_comb begin
				azo_n = azo_s[k-1];
				if (q_s[k-1] < 0) begin
					p_n = p_s[k-1] - (q_s[k-1] >>> I);
					q_n = q_s[k-1] + (p_s[k-1] >>> I);
					acc_n = acc_s[k-1] - ATV;
				end else begin
					p_n = p_s[k-1] + (q_s[k-1] >>> I);
					q_n = q_s[k-1] - (p_s[k-1] >>> I);
					acc_n = acc_s[k-1] + ATV;
				end
			end
		end else begin : g_hold
			assign p_n = p_s[k-1];
			assign q_n = q_s[k-1];
			assign acc_n = acc_s[k-1];
			assign azo_n = azo_s[k-1];
		end

		if (k <= CB + 1) begin : g_sqrt
			localparam int J = CB + 1 - k;
			logic [RW-1:0] remx, trial;
			always_comb begin
				remx = {rem_s[k-1][RW-3:0], n_s[k-1][2*J+1 -: 2]};
				trial = RW'({root_s[k-1], 2'b01});
				if (remx >= trial) begin
					rem_n = remx - trial;
					root_n = {root_s[k-1][CB-2:0], 1'b1};
				end else begin
					rem_n = remx;
					root_n = {root_s[k-1][CB-2:0], 1'b0};
				end
			end
		end else begin : g_sqhold
			assign rem_n = rem_s[k-1];
			assign root_n = root_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_s[k] <= p_n;
				q_s[k] <= q_n;
				acc_s[k] <= acc_n;
				zg_s[k] <= zg_s[k-1];
				azo_s[k] <= azo_n;
				fl_s[k] <= fl_s[k-1];
				rem_s[k] <= rem_n;
				root_s[k] <= root_n;
				n_s[k] <= n_s[k-1];
			end
		end
	end

	// ---------------- output register: clamp, mirror and round the polar angle ----------------
	logic signed [AW-1:0] t_clamp, t_mir, t_rnd;
	logic [AB-1:0] pol_n;

	always_comb begin
		priority if (acc_s[M] < 0) begin
			t_clamp = '0;
		end else if (acc_s[M] > QUARTER32) begin
			t_clamp = QUARTER32;
		end else begin
			t_clamp = acc_s[M];
		end
		t_mir = fl_s[M].z_neg ? (HALF32 - t_clamp) : t_clamp;
		t_rnd = t_mir + RND;
		pol_n = fl_s[M].z_zero ? ANG_QUARTER : t_rnd[31 -: AB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[M];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			radius_q <= root_s[M];
			azimuth_q <= azo_s[M];
			polar_q <= pol_n;
		end
	end

	assign out_valid = vld_q;
	assign radius = radius_q;
	assign azimuth = azimuth_q;
	assign polar = polar_q;

	// polar angle never passes a half turn
	a_polar_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (polar <= ANG_HALF))
		else $error("polar angle above half turn");

	// a held pipeline keeps its first stage
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_s[1]))
		else $error("stage 1 changed while stalled");

	// an item in the last stage reaches the output register when the pipe moves
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[M] && !in_stall) |=> out_valid)
		else $error("item lost at output register");

endmodule
